### design/spmh_pkg.sv
// Shared constants, tables and pipeline types for the salted power-mod hash.
`default_nettype none
package spmh_pkg;

   localparam int DIGIT_COUNT = 9;
   localparam int PAIR_COUNT = 5;
   localparam int DIGIT_BASE = 5;
   localparam int POWER_STEPS = 5;
   localparam int SUM_LIMIT = 46340;
   localparam int RECIP_SHIFT = 30;

   localparam int KEY_W = 16;
   localparam int SALT_W = 10;
   localparam int SEL_W = 3;
   localparam int HASH_W = 15;
   localparam int X_W = 16;
   localparam int SUM_W = 21;
   localparam int PROD_W = 30;
   localparam int RECIP_W = 16;
   localparam int REM_W = 16;
   localparam int DIGIT_W = 3;
   localparam int PRIME_W = 19;

   localparam logic [SEL_W-1:0] MAX_SEL = SEL_W'(PAIR_COUNT - 1);

   localparam logic [PRIME_W-1:0] PRIME_TAB [PAIR_COUNT] = '{
      19'd306133, 19'd307189, 19'd307823, 19'd308887, 19'd310693
   };
   localparam logic [HASH_W-1:0] MOD_TAB [PAIR_COUNT] = '{
      15'd26407, 15'd26687, 15'd27259, 15'd26717, 15'd27197
   };

   typedef logic [DIGIT_W-1:0] digit_type;
   typedef digit_type [DIGIT_COUNT-1:0] digit_row_type;
   typedef digit_row_type [PAIR_COUNT-1:0] digit_tab_type;
   typedef logic [RECIP_W-1:0] recip_type;
   typedef recip_type [PAIR_COUNT-1:0] recip_tab_type;

   // base-5 digits of each prime, written highest digit first
   localparam digit_row_type DIGITS_0 = '{
      3'd0, 3'd3, 3'd4, 3'd2, 3'd4, 3'd4, 3'd0, 3'd1, 3'd3
   };
   localparam digit_row_type DIGITS_1 = '{
      3'd0, 3'd3, 3'd4, 3'd3, 3'd1, 3'd2, 3'd2, 3'd2, 3'd4
   };
   localparam digit_row_type DIGITS_2 = '{
      3'd0, 3'd3, 3'd4, 3'd3, 3'd2, 3'd2, 3'd2, 3'd4, 3'd3
   };
   localparam digit_row_type DIGITS_3 = '{
      3'd0, 3'd3, 3'd4, 3'd3, 3'd4, 3'd1, 3'd0, 3'd2, 3'd2
   };
   localparam digit_row_type DIGITS_4 = '{
      3'd0, 3'd3, 3'd4, 3'd4, 3'd2, 3'd0, 3'd2, 3'd3, 3'd3
   };

   localparam digit_tab_type DIGIT_TAB = '{
      DIGITS_4, DIGITS_3, DIGITS_2, DIGITS_1, DIGITS_0
   };

   // floor(2^30 / m), last pair first: quotient estimate is exact or one low
   localparam recip_tab_type RECIP_TAB = '{
      16'd39480, 16'd40189, 16'd39390, 16'd40234, 16'd40661
   };

   typedef struct packed {
      logic valid;
      logic err;
      logic [SEL_W-1:0] sel;
      logic [X_W-1:0] x;
      logic [HASH_W-1:0] xr;
      logic [HASH_W-1:0] r;
      logic [SUM_W-1:0] sum;
   } pipe_type;

endpackage
`default_nettype wire

### design/spmh_red.sv
// Three-stage reduction of a product modulo the selected modulus.
`default_nettype none
module spmh_red
   import spmh_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire pipe_type pipe_i,
   input  wire logic [PROD_W-1:0] p_i,
   output pipe_type pipe_o,
   output logic [HASH_W-1:0] rem_o
);

   pipe_type s1_ff, s2_ff, s3_ff;
   logic [PROD_W-1:0] p1_ff;
   logic [RECIP_W-1:0] t_ff, t_in;
   logic [REM_W-1:0] r_ff, r_in;
   logic [HASH_W-1:0] rem_ff, rem_in;
   logic [PROD_W+RECIP_W-1:0] wide;
   logic [PROD_W:0] qm;
   logic [PROD_W:0] diff;
   logic [HASH_W-1:0] m1, m2;

   always_comb begin
      wide = (PROD_W+RECIP_W)'(p_i) * (PROD_W+RECIP_W)'(RECIP_TAB[pipe_i.sel]);
      t_in = wide[PROD_W+RECIP_W-1:RECIP_SHIFT];
      m1 = MOD_TAB[s1_ff.sel];
      qm = (PROD_W+1)'(t_ff) * (PROD_W+1)'(m1);
      diff = (PROD_W+1)'(p1_ff) - qm;
      r_in = diff[REM_W-1:0];
      m2 = MOD_TAB[s2_ff.sel];
      if (r_ff >= REM_W'(m2)) begin
         rem_in = HASH_W'(r_ff - REM_W'(m2));
      end else begin
         rem_in = HASH_W'(r_ff);
      end
   end

   always_ff @(posedge clock) begin
      p1_ff <= p_i;
      t_ff <= t_in;
      r_ff <= r_in;
      rem_ff <= rem_in;
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
         s3_ff <= '0;
      end else begin
         s1_ff <= pipe_i;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
      end
   end

   assign pipe_o = s3_ff;
   assign rem_o = rem_ff;

endmodule
`default_nettype wire

### design/spmh_cell.sv
// Power cell: multiplies the running power by x and reduces it mod m.
`default_nettype none
module spmh_cell
   import spmh_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire pipe_type pipe_i,
   output pipe_type pipe_o
);

   pipe_type pipe_ff;
   logic [PROD_W-1:0] p_ff, p_in;
   pipe_type red_pipe;
   logic [HASH_W-1:0] red_rem;

   assign p_in = PROD_W'(pipe_i.r) * PROD_W'(pipe_i.xr);

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      if (reset) begin
         pipe_ff <= '0;
      end else begin
         pipe_ff <= pipe_i;
      end
   end

   spmh_red u_red (
      .clock (clock),
      .reset (reset),
      .pipe_i(pipe_ff),
      .p_i   (p_ff),
      .pipe_o(red_pipe),
      .rem_o (red_rem)
   );

   always_comb begin
      pipe_o = red_pipe;
      pipe_o.r = red_rem;
   end

endmodule
`default_nettype wire

### design/spmh_digit.sv
// Digit cell: adds x times one prime digit to the sum and seeds the power chain.
`default_nettype none
module spmh_digit
   import spmh_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire pipe_type pipe_i,
   input  wire logic [DIGIT_W-1:0] digit_i,
   output pipe_type pipe_o
);

   pipe_type pipe_ff, pipe_in;
   logic [HASH_W-1:0] m;

   always_comb begin
      m = MOD_TAB[pipe_i.sel];
      pipe_in = pipe_i;
      pipe_in.sum = pipe_i.sum + SUM_W'(pipe_i.x) * SUM_W'(digit_i);
      // x is below twice m, so one subtract reduces it
      if (pipe_i.x >= X_W'(m)) begin
         pipe_in.xr = HASH_W'(pipe_i.x - X_W'(m));
      end else begin
         pipe_in.xr = HASH_W'(pipe_i.x);
      end
      pipe_in.r = pipe_in.xr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_ff <= '0;
      end else begin
         pipe_ff <= pipe_in;
      end
   end

   assign pipe_o = pipe_ff;

endmodule
`default_nettype wire

### design/salted_power_mod_hash_top.sv
// Top level: input stage, row of digit and power cells, final reduction.
// The result strobe travels with its item through every pipeline register.
// Throughput: one item per cycle; busy is always low and the chain never stalls.
// Each of the first eight digits feeds five power cells of four stages each.
// Reset empties the item registers along the chain; results cannot be held off.
`default_nettype none
module salted_power_mod_hash_top
   import spmh_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire logic [KEY_W-1:0] req_key,
   input  wire logic [SALT_W-1:0] req_salt,
   input  wire logic [SEL_W-1:0] req_hash_select,
   output logic rsp_valid,
   output logic [HASH_W-1:0] rsp_hash_value,
   output logic rsp_range_error
);

   pipe_type front_ff, front_in;
   logic [X_W:0] x_full;
   pipe_type dig_in [DIGIT_COUNT];
   pipe_type dig_out [DIGIT_COUNT];
   pipe_type cell_io [DIGIT_COUNT-1][POWER_STEPS+1];
   pipe_type fin_pipe;
   logic [HASH_W-1:0] fin_rem;
   logic valid_ff;
   logic [HASH_W-1:0] hash_ff;
   logic err_ff;

   assign busy = 1'b0;

   always_comb begin
      x_full = (X_W+1)'(req_key) + (X_W+1)'(req_salt);
      front_in = '0;
      front_in.valid = start;
      front_in.err = (x_full > (X_W+1)'(SUM_LIMIT));
      front_in.x = front_in.err ? '0 : x_full[X_W-1:0];
      front_in.sel = (req_hash_select > MAX_SEL) ? MAX_SEL : req_hash_select;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
      end else begin
         front_ff <= front_in;
      end
   end

   assign dig_in[0] = front_ff;

   for (genvar d = 0; d < DIGIT_COUNT; d++) begin : g_digit
      spmh_digit u_digit (
         .clock  (clock),
         .reset  (reset),
         .pipe_i (dig_in[d]),
         .digit_i(DIGIT_TAB[dig_in[d].sel][d]),
         .pipe_o (dig_out[d])
      );
      if (d < DIGIT_COUNT - 1) begin : g_power
         assign cell_io[d][0] = dig_out[d];
         for (genvar k = 0; k < POWER_STEPS; k++) begin : g_cell
            spmh_cell u_cell (
               .clock (clock),
               .reset (reset),
               .pipe_i(cell_io[d][k]),
               .pipe_o(cell_io[d][k+1])
            );
         end
         // x^6 mod m becomes the next digit's x
         always_comb begin
            dig_in[d+1] = cell_io[d][POWER_STEPS];
            dig_in[d+1].x = X_W'(cell_io[d][POWER_STEPS].r);
         end
      end
   end

   spmh_red u_final (
      .clock (clock),
      .reset (reset),
      .pipe_i(dig_out[DIGIT_COUNT-1]),
      .p_i   (PROD_W'(dig_out[DIGIT_COUNT-1].sum)),
      .pipe_o(fin_pipe),
      .rem_o (fin_rem)
   );

   always_ff @(posedge clock) begin
      hash_ff <= fin_pipe.err ? '0 : fin_rem;
      err_ff <= fin_pipe.err;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= fin_pipe.valid;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_hash_value = hash_ff;
   assign rsp_range_error = err_ff;

endmodule
`default_nettype wire

### verif/salted_power_mod_hash_checker.sv
// Checker for the salted power-mod hash: predicts each hash and compares the results.
`default_nettype none
module salted_power_mod_hash_checker
   import spmh_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic busy,
   input  wire logic [KEY_W-1:0] req_key,
   input  wire logic [SALT_W-1:0] req_salt,
   input  wire logic [SEL_W-1:0] req_hash_select,
   input  wire logic rsp_valid,
   input  wire logic [HASH_W-1:0] rsp_hash_value,
   input  wire logic rsp_range_error,
   output int fail_count,
   output int pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [HASH_W-1:0] hash_value;
      logic range_error;
   } hash_result_type;

   hash_result_type expected_hashes[$];

   function automatic hash_result_type predict_hash(logic [KEY_W-1:0] key,
      logic [SALT_W-1:0] salt, logic [SEL_W-1:0] sel_in);
      hash_result_type res;
      longint unsigned x, prime, m, acc, pw;
      int unsigned sel;
      sel = (sel_in > MAX_SEL) ? int'(MAX_SEL) : int'(sel_in);
      x = longint'(key) + longint'(salt);
      res = '0;
      if (x > SUM_LIMIT) begin
         res.range_error = 1'b1;
         return res;
      end
      prime = PRIME_TAB[sel];
      m = MOD_TAB[sel];
      acc = 0;
      for (int d = 0; d < DIGIT_COUNT; d++) begin
         acc += x * (prime % DIGIT_BASE);
         prime /= DIGIT_BASE;
         pw = x;
         for (int k = 0; k < POWER_STEPS; k++) pw = (pw * x) % m;
         x = pw;
      end
      res.hash_value = HASH_W'(acc % m);
      return res;
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t: mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   initial fail_count = 0;
   assign pending_count = expected_hashes.size();

   always @(posedge clock) begin
      hash_result_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_hashes.size() == 0) begin
               report_mismatch("result with no item outstanding");
            end else begin
               want = expected_hashes.pop_front();
               if (rsp_hash_value !== want.hash_value)
                  report_mismatch($sformatf("hash_value got %0d want %0d",
                     rsp_hash_value, want.hash_value));
               if (rsp_range_error !== want.range_error)
                  report_mismatch($sformatf("range_error got %0b want %0b",
                     rsp_range_error, want.range_error));
            end
         end
         if (start && !busy)
            expected_hashes.push_back(predict_hash(req_key, req_salt, req_hash_select));
      end
   end
endmodule
`default_nettype wire

### verif/salted_power_mod_hash_top_tb.sv
// Testbench top: clock, reset, item stimulus and the final verdict.
`default_nettype none
module salted_power_mod_hash_top_tb;
   import spmh_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [KEY_W-1:0] req_key = '0;
   logic [SALT_W-1:0] req_salt = '0;
   logic [SEL_W-1:0] req_hash_select = '0;
   logic rsp_valid;
   logic [HASH_W-1:0] rsp_hash_value;
   logic rsp_range_error;
   int fail_count, pending_count;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   salted_power_mod_hash_top dut (.*);

   salted_power_mod_hash_checker checker_inst (.*);

   // hold one item until accepted; start stays high until the caller drops it
   task automatic send_item(int key, int salt, int sel);
      req_key <= KEY_W'(key);
      req_salt <= SALT_W'(salt);
      req_hash_select <= SEL_W'(sel);
      start <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // back-to-back burst: start stays high across items
   task automatic send_burst(int count);
      int key, salt;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0: key = $urandom_range(0, 65535);
            1: key = 46340 - $urandom_range(0, 1023) + $urandom_range(0, 2);
            default: key = $urandom_range(0, 45341);
         endcase
         salt = $urandom_range(0, 1023);
         req_key <= KEY_W'(key);
         req_salt <= SALT_W'(salt);
         req_hash_select <= SEL_W'($urandom_range(0, 7));
         start <= 1'b1;
         do @(posedge clock); while (busy);
         @(negedge clock);
      end
   endtask

   initial begin
      int sent, n, waited;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // directed: field extremes, every selector, range boundary
      for (int s = 0; s < 8; s++) send_item(0, 0, s);
      for (int s = 0; s < 5; s++) send_item(45341, 0, s);
      send_item(46340, 0, 2);
      send_item(46341, 0, 1);
      send_item(45317, 1023, 3);
      send_item(45318, 1023, 4);
      send_item(65535, 1023, 7);
      send_item(1, 1, 0);
      send_item(45341, 1023, 0);
      send_item(32768, 0, 5);
      send_item(0, 1023, 6);
      start <= 1'b0;
      @(negedge clock);
      sent = 0;
      while (sent < 600) begin
         n = $urandom_range(1, 30);
         send_burst(n);
         sent += n;
         if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
      start <= 1'b0;
      waited = 0;
      while (pending_count != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      repeat (200) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire
